/* rtl/vlt_pkg.sv */
// ----------------------------------------------------------------------------
// vlt_pkg: shared types and constants for the voxel line traversal
// Field widths, grid limits, DDA scaling and the command and status groups
// that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package vlt_pkg;

	// grid and sequence limits
	localparam int GRID_X     = 512;
	localparam int GRID_Z     = 64;
	localparam int MAX_POINTS = 64;

	// field widths
	localparam int XY_W  = 9;
	localparam int Z_W   = 6;
	localparam int IDX_W = 6;

	// internal widths
	localparam int CUR_W   = 10;                 // start plus up to 63 moves
	localparam int NEXT_W  = 14;                 // holds GRID_X/GRID_Z up to 4096
	localparam int MAG_W   = 9;                  // |delta| at setup
	localparam int FRAC_W  = 10;                 // DDA scale of 1024
	localparam int QUO_W   = MAG_W + FRAC_W;     // dividend and quotient
	localparam int CNT_W   = $clog2(QUO_W);
	localparam int INC_W   = 21;
	localparam int ACC_W   = 28;

	localparam int DDA_ONE = 1024;
	localparam logic [INC_W-1:0] DDA_NO_MOVE = INC_W'(32'h3fffffff / 512);

	typedef enum logic [1:0] {
		REASON_END   = 2'd0,
		REASON_LIMIT = 2'd1,
		REASON_GRID  = 2'd2
	} reason_t;

	// request: one line segment
	typedef struct packed {
		logic [XY_W-1:0] start_x;
		logic [XY_W-1:0] start_y;
		logic [Z_W-1:0]  start_z;
		logic [XY_W-1:0] end_x;
		logic [XY_W-1:0] end_y;
		logic [Z_W-1:0]  end_z;
	} seg_t;

	// result: one voxel on the line
	typedef struct packed {
		logic [XY_W-1:0]  point_x;
		logic [XY_W-1:0]  point_y;
		logic [Z_W-1:0]   point_z;
		logic [IDX_W-1:0] point_index;
		logic             last;
		reason_t          end_reason;
	} vox_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic setup;
		logic div_start;
		logic div_sel;
		logic init_acc;
		logic step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic out_free;
		logic last_now;
	} sts_t;

endpackage

/* rtl/vlt_div.sv */
// ----------------------------------------------------------------------------
// vlt_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses for one cycle
// once the quotient is in place.
// ----------------------------------------------------------------------------
module vlt_div
	import vlt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [QUO_W-1:0] dividend,
	input  logic [MAG_W-1:0] divisor,
	output logic [QUO_W-1:0] quotient,
	output logic             done
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [MAG_W:0]   trial;
	logic             fits;

	// trial subtract of the shifted partial remainder
	always_comb begin
		trial = {rem_q, quo_q[QUO_W-1]};
		fits  = trial >= {1'b0, divisor};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(QUO_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? MAG_W'(trial - {1'b0, divisor}) : trial[MAG_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

/* rtl/vlt_dp.sv */
// ----------------------------------------------------------------------------
// vlt_dp: traversal datapath
// Holds the current and end voxel, deltas, increments and accumulators,
// the shared divider and the output register.
// ----------------------------------------------------------------------------
module vlt_dp
	import vlt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output sts_t sts,
	input  seg_t seg,
	output logic vox_valid,
	input  logic vox_stall,
	output vox_t vox
);

	localparam logic [NEXT_W-1:0] LIM_XY = NEXT_W'(GRID_X);
	localparam logic [NEXT_W-1:0] LIM_Z  = NEXT_W'(GRID_Z);

	logic [CUR_W-1:0] cur_q [3];
	logic [CUR_W-1:0] fin_q [3];
	logic [MAG_W-1:0] mag_q [3];
	logic [2:0]       neg_q;
	logic [1:0]       dom_q;
	logic [INC_W-1:0] inc_q [3];
	logic [ACC_W-1:0] acc_q [3];
	logic [IDX_W-1:0] idx_q;
	logic             vox_valid_q;
	vox_t             vox_q;

	logic [MAG_W-1:0] mag_d [3];
	logic [2:0]       neg_d;
	logic [1:0]       dom_d;
	logic [1:0]       div_axis;
	logic [MAG_W-1:0] divisor;
	logic [MAG_W-1:0] mag_dom;
	logic [QUO_W-1:0] quotient;
	logic             div_done;
	logic             out_free;
	logic             at_end;
	logic             at_lim;
	logic             off_grid;
	logic             last_now;
	logic [1:0]       ax;
	logic [CUR_W-1:0] cur_sel;
	logic             neg_sel;
	logic [NEXT_W-1:0] lim_sel;
	logic [NEXT_W-1:0] nxt;
	reason_t          reason;

	// deltas and dominant axis from the captured segment
	always_comb begin
		logic signed [CUR_W+1:0] d;
		for (int i = 0; i < 3; i++) begin
			d        = $signed({2'b00, fin_q[i]}) - $signed({2'b00, cur_q[i]});
			neg_d[i] = d < 0;
			mag_d[i] = neg_d[i] ? MAG_W'(-d) : MAG_W'(d);
		end
		if (mag_d[0] >= mag_d[1] && mag_d[0] >= mag_d[2])
			dom_d = 2'd0;
		else if (mag_d[1] >= mag_d[2])
			dom_d = 2'd1;
		else
			dom_d = 2'd2;
	end

	// which non-dominant axis the divider is working on
	always_comb begin
		case (dom_q)
			2'd0:    div_axis = cmd.div_sel ? 2'd2 : 2'd1;
			2'd1:    div_axis = cmd.div_sel ? 2'd2 : 2'd0;
			default: div_axis = cmd.div_sel ? 2'd1 : 2'd0;
		endcase
		case (div_axis)
			2'd0:    divisor = mag_q[0];
			2'd1:    divisor = mag_q[1];
			default: divisor = mag_q[2];
		endcase
		case (dom_q)
			2'd0:    mag_dom = mag_q[0];
			2'd1:    mag_dom = mag_q[1];
			default: mag_dom = mag_q[2];
		endcase
	end

	vlt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({mag_dom, FRAC_W'(0)}),
		.divisor  (divisor),
		.quotient (quotient),
		.done     (div_done)
	);

	// step decision: stop conditions, axis choice, grid check
	always_comb begin
		at_end = (cur_q[0] == fin_q[0]) && (cur_q[1] == fin_q[1]) && (cur_q[2] == fin_q[2]);
		at_lim = idx_q == IDX_W'(MAX_POINTS - 1);
		if (acc_q[2] <= acc_q[0] && acc_q[2] <= acc_q[1])
			ax = 2'd2;
		else if (acc_q[0] < acc_q[1])
			ax = 2'd0;
		else
			ax = 2'd1;
		case (ax)
			2'd0: begin
				cur_sel = cur_q[0];
				neg_sel = neg_q[0];
				lim_sel = LIM_XY;
			end
			2'd1: begin
				cur_sel = cur_q[1];
				neg_sel = neg_q[1];
				lim_sel = LIM_XY;
			end
			default: begin
				cur_sel = cur_q[2];
				neg_sel = neg_q[2];
				lim_sel = LIM_Z;
			end
		endcase
		nxt      = neg_sel ? NEXT_W'(cur_sel) - 1'b1 : NEXT_W'(cur_sel) + 1'b1;
		// a step below zero wraps to the top of nxt and fails the compare too
		off_grid = nxt >= lim_sel;
		last_now = at_end || at_lim || off_grid;
		if (at_end)
			reason = REASON_END;
		else if (at_lim)
			reason = REASON_LIMIT;
		else if (off_grid)
			reason = REASON_GRID;
		else
			reason = REASON_END;
	end

	// segment, setup and DDA state
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cur_q[0] <= CUR_W'(seg.start_x);
			cur_q[1] <= CUR_W'(seg.start_y);
			cur_q[2] <= CUR_W'(seg.start_z);
			fin_q[0] <= CUR_W'(seg.end_x);
			fin_q[1] <= CUR_W'(seg.end_y);
			fin_q[2] <= CUR_W'(seg.end_z);
			idx_q    <= '0;
		end
		if (cmd.setup) begin
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= mag_d[i];
				inc_q[i] <= INC_W'(DDA_ONE);
			end
			neg_q <= neg_d;
			dom_q <= dom_d;
		end
		if (div_done) begin
			for (int i = 0; i < 3; i++) begin
				if (div_axis == 2'(i))
					inc_q[i] <= (mag_q[i] == '0) ? DDA_NO_MOVE : INC_W'(quotient);
			end
		end
		if (cmd.init_acc) begin
			for (int i = 0; i < 3; i++) begin
				if (neg_q[i])
					acc_q[i] <= ACC_W'(inc_q[i] >> 1);
				else
					acc_q[i] <= ACC_W'(inc_q[i] - (inc_q[i] >> 1));
			end
		end
		if (cmd.step && !last_now) begin
			for (int i = 0; i < 3; i++) begin
				if (ax == 2'(i)) begin
					cur_q[i] <= nxt[CUR_W-1:0];
					acc_q[i] <= acc_q[i] + ACC_W'(inc_q[i]);
				end
			end
			idx_q <= idx_q + 1'b1;
		end
	end

	// output register
	assign out_free = !vox_valid_q || !vox_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vox_valid_q <= 1'b0;
		else if (cmd.step)
			vox_valid_q <= 1'b1;
		else if (!vox_stall)
			vox_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			vox_q.point_x     <= cur_q[0][XY_W-1:0];
			vox_q.point_y     <= cur_q[1][XY_W-1:0];
			vox_q.point_z     <= cur_q[2][Z_W-1:0];
			vox_q.point_index <= idx_q;
			vox_q.last        <= last_now;
			vox_q.end_reason  <= reason;
		end
	end

	assign vox_valid    = vox_valid_q;
	assign vox          = vox_q;
	assign sts.div_done = div_done;
	assign sts.out_free = out_free;
	assign sts.last_now = last_now;

endmodule

/* rtl/vlt_ctrl.sv */
// ----------------------------------------------------------------------------
// vlt_ctrl: traversal sequencer
// Takes a request, runs setup and the two increment divisions, then steps
// the DDA once per free output slot until the final voxel goes out.
// ----------------------------------------------------------------------------
module vlt_ctrl
	import vlt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic seg_valid,
	output logic seg_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [7:0] {
		ST_IDLE      = 8'b0000_0001,
		ST_SETUP     = 8'b0000_0010,
		ST_DIV0_GO   = 8'b0000_0100,
		ST_DIV0_WAIT = 8'b0000_1000,
		ST_DIV1_GO   = 8'b0001_0000,
		ST_DIV1_WAIT = 8'b0010_0000,
		ST_INIT      = 8'b0100_0000,
		ST_STEP      = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = seg_valid;
				if (seg_valid)
					state_d = ST_SETUP;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_DIV0_GO;
			end
			ST_DIV0_GO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV0_WAIT;
			end
			ST_DIV0_WAIT: begin
				if (sts.div_done)
					state_d = ST_DIV1_GO;
			end
			ST_DIV1_GO: begin
				cmd.div_sel   = 1'b1;
				cmd.div_start = 1'b1;
				state_d       = ST_DIV1_WAIT;
			end
			ST_DIV1_WAIT: begin
				cmd.div_sel = 1'b1;
				if (sts.div_done)
					state_d = ST_INIT;
			end
			ST_INIT: begin
				cmd.init_acc = 1'b1;
				state_d      = ST_STEP;
			end
			ST_STEP: begin
				cmd.step = sts.out_free;
				if (sts.out_free && sts.last_now)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign seg_stall = state_q != ST_IDLE;

endmodule

/* rtl/voxel_line_traversal.sv */
// ----------------------------------------------------------------------------
// voxel_line_traversal: 3D voxel line walk by fixed-point DDA
// Channel  Dir  Payload  Handshake
// seg      in   seg_t    seg_valid / seg_stall  start and end voxel
// vox      out  vox_t    vox_valid / vox_stall  one voxel on the line
//
// A request first runs setup and the two increment divisions on the shared
// bit-serial divider, then yields one voxel per cycle while the output is
// not stalled, up to 64 voxels. One request at a time.
// Reset clears the sequencer and the output valid.
// A stall on vox holds the output register and pauses the DDA step.
// ----------------------------------------------------------------------------
module voxel_line_traversal
	import vlt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic seg_valid,
	output logic seg_stall,
	input  seg_t seg,
	output logic vox_valid,
	input  logic vox_stall,
	output vox_t vox
);

	cmd_t cmd;
	sts_t sts;

	vlt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	vlt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.seg       (seg),
		.vox_valid (vox_valid),
		.vox_stall (vox_stall),
		.vox       (vox)
	);

endmodule

/* rtl/vlt_checker.sv */
// ----------------------------------------------------------------------------
// vlt_checker: port-level checks for the voxel line traversal
// Watches both channels of the top level; bound in below.
// ----------------------------------------------------------------------------
module vlt_checker
	import vlt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic seg_valid,
	input logic seg_stall,
	input logic vox_valid,
	input logic vox_stall,
	input vox_t vox
);

	// a stalled voxel holds
	a_vox_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vox_valid && vox_stall |=> vox_valid && $stable(vox))
		else $error("voxel changed under stall");

	// a taken request blocks the next one
	a_seg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !seg_stall |=> seg_stall)
		else $error("request taken while a line is in progress");

	// no new request while a line is only partly out
	a_line_open: assert property (@(posedge clk) disable iff (!arst_n)
		vox_valid && !vox.last |-> seg_stall)
		else $error("request accepted before the final voxel");

	// the point limit always closes the line
	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		vox_valid && vox.point_index == IDX_W'(MAX_POINTS - 1) |-> vox.last)
		else $error("voxel at point limit not marked last");

endmodule

bind voxel_line_traversal vlt_checker u_chk (.*);
